>>> design/shaps_pkg.sv
// Shared types, constants and functions for the SHA-256 padding and message schedule block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package shaps_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_WORDS  = 16;
    localparam int POS_W        = 6;
    localparam int COUNT_W      = 61;
    localparam int PAIR_W       = 5;
    localparam int QUEUE_DEPTH  = 2;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 72;

    localparam logic [7:0]        PAD_BYTE  = 8'h80;
    localparam logic [POS_W-1:0]  LAST_POS  = 6'd63;
    localparam logic [POS_W-1:0]  PAD_LIMIT = 6'd56;
    localparam logic [PAIR_W-1:0] LAST_PAIR = 5'd31;

    typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] window_t;

    typedef struct packed {
        logic    msg_last;
        window_t words;
    } block_t;

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

>>> design/sha256_pad_and_schedule.sv
// Top level of the SHA-256 padding and message schedule block.
// Joins shaps_front, shaps_queue and shaps_back; depends on shaps_pkg.
//
//   Channel   Direction   Beat carries
//   s_*       in          tdata[7:0] byte, tuser byte present, tlast end of message
//   m_*       out         tdata word pair and pair index, tuser end of message,
//                         tlast end of block
//
// A byte beat is taken whenever s_tready is high; a beat that completes a block or ends
// the message holds s_tready low while blocks are handed to the queue, and while the
// queue is full. Schedule expansion produces one pair per cycle while m_tready is high;
// a block is 32 pairs on m_*.
// The queue holds two blocks; a hand-off from the front waits only while it is full.
// Reset clears the partial block, the byte count and all queued work.
`default_nettype none

module sha256_pad_and_schedule (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [shaps_pkg::IN_TDATA_W-1:0]    s_tdata,   // data_byte
    input  wire logic                                s_tuser,   // byte_present
    input  wire logic                                s_tlast,   // last
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [shaps_pkg::OUT_TDATA_W-1:0]        m_tdata,   // word_even, word_odd,
                                                                // pair_index, zeros
    output logic                                     m_tuser,   // message_last
    output logic                                     m_tlast    // block_last
);
    import shaps_pkg::*;

    logic              push_valid, push_ready;
    block_t            push_data;
    logic              pop_valid, pop_ready;
    block_t            pop_data;
    logic [WORD_W-1:0] out_even, out_odd;
    logic [PAIR_W-1:0] out_index;

    shaps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_present (s_tuser),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    shaps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    shaps_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (pop_valid),
        .q_ready        (pop_ready),
        .q_data         (pop_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_even       (out_even),
        .out_odd        (out_odd),
        .out_index      (out_index),
        .out_block_last (m_tlast),
        .out_msg_last   (m_tuser)
    );

    assign m_tdata = {(OUT_TDATA_W - 2 * WORD_W - PAIR_W)'(0), out_index, out_odd, out_even};

`ifndef SYNTHESIS
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("Block handed to a full queue.");

    a_msg_last_on_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("End of message outside the final pair of a block.");

    a_block_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> out_index == LAST_PAIR)
        else $error("End of block on a pair other than the last.");
`endif

endmodule

`default_nettype wire

>>> design/shaps_front.sv
// Front part: packs message bytes into a block window, applies padding and the length.
// Hands finished blocks to the block queue; depends on shaps_pkg.
`default_nettype none

module shaps_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [7:0]              in_byte,
    input  wire logic                    in_present,
    input  wire logic                    in_last,
    output logic                         push_valid,
    input  wire logic                    push_ready,
    output shaps_pkg::block_t            push_data
);
    import shaps_pkg::*;

    localparam logic [2:0] S_TAKE = 3'd0;
    localparam logic [2:0] S_FULL = 3'd1;
    localparam logic [2:0] S_PAD  = 3'd2;
    localparam logic [2:0] S_OVF  = 3'd3;
    localparam logic [2:0] S_LEN  = 3'd4;

    logic [2:0]         state_reg, state_next;
    window_t            window_reg, window_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               last_pend_reg, last_pend_next;

    function automatic window_t put_byte(input window_t w, input logic [POS_W-1:0] pos,
                                         input logic [7:0] value);
        window_t r;
        r = w;
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            for (int b = 0; b < 4; b++) begin
                if (pos == POS_W'(i * 4 + b)) begin
                    r[i][8*(3-b) +: 8] = value;
                end
            end
        end
        return r;
    endfunction

    assign in_ready = (state_reg == S_TAKE);

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        last_pend_next = last_pend_reg;
        push_valid     = 1'b0;
        push_data      = '{msg_last: 1'b0, words: window_reg};
        unique case (state_reg)
            S_TAKE:
            begin
                if (in_valid) begin
                    if (in_present) begin
                        window_next = put_byte(window_reg, pos_reg, in_byte);
                        pos_next    = pos_reg + 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                    if (in_present && pos_reg == LAST_POS) begin
                        state_next     = S_FULL;
                        last_pend_next = in_last;
                    end else if (in_last) begin
                        state_next = S_PAD;
                    end
                end
            end
            S_FULL:
            begin
                if (push_ready) begin
                    push_valid  = 1'b1;
                    window_next = '0;
                    state_next  = last_pend_reg ? S_PAD : S_TAKE;
                end
            end
            S_PAD:
            begin
                window_next = put_byte(window_reg, pos_reg, PAD_BYTE);
                pos_next    = pos_reg + 1'b1;
                state_next  = (pos_reg >= PAD_LIMIT) ? S_OVF : S_LEN;
            end
            S_OVF:
            begin
                if (push_ready) begin
                    push_valid  = 1'b1;
                    window_next = '0;
                    pos_next    = '0;
                    state_next  = S_LEN;
                end
            end
            S_LEN:
            begin
                push_data.msg_last  = 1'b1;
                push_data.words[14] = count_reg[60:29];
                push_data.words[15] = {count_reg[28:0], 3'b000};
                if (push_ready) begin
                    push_valid  = 1'b1;
                    window_next = '0;
                    pos_next    = '0;
                    count_next  = '0;
                    state_next  = S_TAKE;
                end
            end
            default:
            begin
                state_next = S_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_TAKE;
            window_reg    <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            last_pend_reg <= last_pend_next;
        end
    end

endmodule

`default_nettype wire

>>> design/shaps_queue.sv
// Short block queue between the front and back parts.
// Holds whole blocks with their end-of-message flag; depends on shaps_pkg.
`default_nettype none

module shaps_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire shaps_pkg::block_t  push_data,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output shaps_pkg::block_t       pop_data
);
    import shaps_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    block_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> design/shaps_back.sv
// Back part: expands each queued block into its 64 schedule words, two per beat.
// Drives the registered result stage; depends on shaps_pkg.
`default_nettype none

module shaps_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    output logic                           q_ready,
    input  wire shaps_pkg::block_t         q_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [shaps_pkg::WORD_W-1:0]   out_even,
    output logic [shaps_pkg::WORD_W-1:0]   out_odd,
    output logic [shaps_pkg::PAIR_W-1:0]   out_index,
    output logic                           out_block_last,
    output logic                           out_msg_last
);
    import shaps_pkg::*;

    window_t             win_reg, win_next;
    logic [PAIR_W-1:0]   idx_reg, idx_next;
    logic                busy_reg, busy_next;
    logic                mlast_reg, mlast_next;
    logic                ov_reg, ov_next;
    logic [WORD_W-1:0]   oe_reg, oo_reg;
    logic [PAIR_W-1:0]   oidx_reg;
    logic                oblast_reg, omlast_reg;
    logic [WORD_W-1:0]   w_new0, w_new1;
    logic                adv, last_adv, load;

    assign adv      = busy_reg && (!ov_reg || out_ready);
    assign last_adv = adv && (idx_reg == LAST_PAIR);
    assign load     = q_valid && (!busy_reg || last_adv);
    assign q_ready  = load;

    assign w_new0 = win_reg[0] + small_sigma0(win_reg[1]) + win_reg[9]
                  + small_sigma1(win_reg[14]);
    assign w_new1 = win_reg[1] + small_sigma0(win_reg[2]) + win_reg[10]
                  + small_sigma1(win_reg[15]);

    always_comb
    begin
        win_next   = win_reg;
        idx_next   = idx_reg;
        mlast_next = mlast_reg;
        busy_next  = busy_reg;
        ov_next    = ov_reg;
        if (adv) begin
            ov_next  = 1'b1;
            idx_next = idx_reg + 1'b1;
            for (int i = 0; i < BLOCK_WORDS - 2; i++) begin
                win_next[i] = win_reg[i+2];
            end
            win_next[BLOCK_WORDS-2] = w_new0;
            win_next[BLOCK_WORDS-1] = w_new1;
        end else if (out_ready) begin
            ov_next = 1'b0;
        end
        if (load) begin
            win_next   = q_data.words;
            idx_next   = '0;
            mlast_next = q_data.msg_last;
            busy_next  = 1'b1;
        end else if (last_adv) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (adv) begin
            oe_reg     <= win_reg[0];
            oo_reg     <= win_reg[1];
            oidx_reg   <= idx_reg;
            oblast_reg <= (idx_reg == LAST_PAIR);
            omlast_reg <= mlast_reg && (idx_reg == LAST_PAIR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            mlast_reg <= 1'b0;
            busy_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            mlast_reg <= mlast_next;
            busy_reg  <= busy_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid      = ov_reg;
    assign out_even       = oe_reg;
    assign out_odd        = oo_reg;
    assign out_index      = oidx_reg;
    assign out_block_last = oblast_reg;
    assign out_msg_last   = omlast_reg;

endmodule

`default_nettype wire
